// ===== rtl/id3p_pkg.sv =====
`default_nettype none
package id3p_pkg;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_SIG   = 3'd1,
    PH_VER   = 3'd2,
    PH_FLAGS = 3'd3,
    PH_SIZE  = 3'd4,
    PH_FRAME = 3'd5,
    PH_SKIP  = 3'd6
  } phase_t;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_FRAME  = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;
  localparam logic [1:0] KIND_END    = 2'd3;

  localparam logic [7:0] SIG_0 = "I";
  localparam logic [7:0] SIG_1 = "D";
  localparam logic [7:0] SIG_2 = "3";

  localparam logic [7:0] VER_0 = 8'h00;
  localparam logic [7:0] VER_2 = 8'h02;
  localparam logic [7:0] VER_3 = 8'h03;
  localparam logic [7:0] VER_4 = 8'h04;

  localparam int FRAME_ID_COUNT = 74;

  localparam logic [31:0] FRAME_IDS [FRAME_ID_COUNT] = '{
    "AENC", "APIC", "COMM", "COMR", "ENCR", "EQUA", "ETCO", "GEOB", "GRID", "IPLS",
    "LINK", "MCDI", "MLLT", "OWNE", "PRIV", "PCNT", "POPM", "POSS", "RBUF", "RVAD",
    "RVRB", "SYLT", "SYTC", "TALB", "TBPM", "TCOM", "TCON", "TCOP", "TDAT", "TDLY",
    "TENC", "TEXT", "TFLT", "TIME", "TIT1", "TIT2", "TIT3", "TKEY", "TLAN", "TLEN",
    "TMED", "TOAL", "TOFN", "TOLY", "TOPE", "TORY", "TOWN", "TPE1", "TPE2", "TPE3",
    "TPE4", "TPOS", "TPUB", "TRCK", "TRDA", "TRSN", "TRSO", "TSIZ", "TSRC", "TSSE",
    "TYER", "TXXX", "UFID", "USER", "USLT", "WCOM", "WCOP", "WOAF", "WOAR", "WOAS",
    "WORS", "WPAY", "WPUB", "WXXX"
  };

  typedef struct packed {
    logic [1:0]  record_kind;
    logic [7:0]  version_major;
    logic        unsync_flag;
    logic        extended_header_flag;
    logic        experimental_flag;
    logic [27:0] tag_size;
    logic [31:0] frame_id;
    logic [6:0]  frame_code;
    logic [31:0] frame_size;
    logic [15:0] frame_flags;
    logic        last_of_run;
  } rec_t;

  typedef struct packed {
    logic [1:0] count;
    rec_t       first;
    rec_t       second;
  } push_t;

  function automatic logic [6:0] frame_code_of(input logic [31:0] id);
    logic [6:0] code;
    code = '0;
    for (int k = 0; k < FRAME_ID_COUNT; k++) begin
      if (FRAME_IDS[k] == id) begin
        code = 7'(k + 1);
      end
    end
    return code;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/id3p_if.sv =====
`default_nettype none
interface id3p_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_tag;

  modport source (output valid, output data_byte, output start_of_tag, input ready);
  modport sink (input valid, input data_byte, input start_of_tag, output ready);
endinterface

interface id3p_rec_if;
  logic        valid;
  logic        ready;
  logic [1:0]  record_kind;
  logic [7:0]  version_major;
  logic        unsync_flag;
  logic        extended_header_flag;
  logic        experimental_flag;
  logic [27:0] tag_size;
  logic [31:0] frame_id;
  logic [6:0]  frame_code;
  logic [31:0] frame_size;
  logic [15:0] frame_flags;
  logic        last_of_run;

  modport source (
    output valid, output record_kind, output version_major, output unsync_flag,
    output extended_header_flag, output experimental_flag, output tag_size,
    output frame_id, output frame_code, output frame_size, output frame_flags,
    output last_of_run, input ready
  );
  modport sink (
    input valid, input record_kind, input version_major, input unsync_flag,
    input extended_header_flag, input experimental_flag, input tag_size,
    input frame_id, input frame_code, input frame_size, input frame_flags,
    input last_of_run, output ready
  );
endinterface
`default_nettype wire

// ===== rtl/id3p_parse.sv =====
`default_nettype none
module id3p_parse (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          take,
  input  wire logic [7:0]    data_byte,
  input  wire logic          start_of_tag,
  output id3p_pkg::push_t    push
);
  import id3p_pkg::*;

  typedef struct packed {
    phase_t      phase;
    logic [3:0]  cnt;
    logic [7:0]  hver;
    logic [2:0]  hflags;
    logic [27:0] body_size;
    logic [27:0] body_pos;
    logic [31:0] id_shift;
    logic [31:0] size_shift;
    logic [15:0] flags_shift;
    logic [31:0] skip_rem;
  } pstate_t;

  pstate_t st;
  pstate_t st_next;
  pstate_t cur;

  logic [27:0] size7;
  logic [27:0] pos_inc;
  logic [3:0]  cnt_inc;
  logic [15:0] flags_new;
  logic [31:0] skip_dec;
  logic [6:0]  code;
  logic [7:0]  sig_char;
  logic        body_end;
  logic        ver_ok;
  logic        walk;
  logic        padding;
  logic        frame_done;
  logic [27:0] hsize;
  rec_t        hdr_rec;
  rec_t        rec_a;
  rec_t        rec_b;
  logic [1:0]  rec_count;

  always_comb begin
    cur = st;
    if (start_of_tag) begin
      cur = pstate_t'('0);
      cur.phase = PH_SIG;
    end
  end

  assign size7      = {cur.size_shift[20:0], data_byte[6:0]};
  assign pos_inc    = cur.body_pos + 28'd1;
  assign cnt_inc    = cur.cnt + 4'd1;
  assign flags_new  = {cur.flags_shift[7:0], data_byte};
  assign skip_dec   = cur.skip_rem - 32'd1;
  assign code       = frame_code_of(cur.id_shift);
  assign body_end   = pos_inc >= cur.body_size;
  assign ver_ok     = data_byte inside {VER_0, VER_2, VER_3, VER_4};
  assign walk       = (cur.hver == VER_3 || cur.hver == VER_4) && size7 != 28'd0;
  assign padding    = code == 7'd0 && cur.size_shift == 32'd0;
  assign frame_done = cur.cnt == 4'd9;
  assign hsize      = (cur.phase == PH_SIZE) ? size7 : cur.body_size;

  always_comb begin
    unique case (cur.cnt[1:0])
      2'd0:    sig_char = SIG_0;
      2'd1:    sig_char = SIG_1;
      default: sig_char = SIG_2;
    endcase
  end

  always_comb begin
    st_next = cur;
    unique case (cur.phase)
      PH_SIG: begin
        if (data_byte != sig_char) begin
          st_next.phase = PH_IDLE;
        end else if (cur.cnt == 4'd2) begin
          st_next.cnt   = '0;
          st_next.phase = PH_VER;
        end else begin
          st_next.cnt = cnt_inc;
        end
      end
      PH_VER: begin
        if (cur.cnt == 4'd0) begin
          if (!ver_ok) begin
            st_next.phase = PH_IDLE;
          end else begin
            st_next.hver = data_byte;
            st_next.cnt  = 4'd1;
          end
        end else begin
          st_next.cnt   = '0;
          st_next.phase = PH_FLAGS;
        end
      end
      PH_FLAGS: begin
        st_next.hflags     = data_byte[7:5];
        st_next.cnt        = '0;
        st_next.size_shift = '0;
        st_next.phase      = PH_SIZE;
      end
      PH_SIZE: begin
        st_next.size_shift = {4'd0, size7};
        if (cur.cnt == 4'd3) begin
          st_next.body_size = size7;
          st_next.body_pos  = '0;
          st_next.cnt       = '0;
          st_next.phase     = walk ? PH_FRAME : PH_IDLE;
        end else begin
          st_next.cnt = cnt_inc;
        end
      end
      PH_FRAME: begin
        if (cur.cnt < 4'd4) begin
          st_next.id_shift = {cur.id_shift[23:0], data_byte};
        end else if (cur.cnt < 4'd8) begin
          st_next.size_shift = {cur.size_shift[23:0], data_byte};
        end else begin
          st_next.flags_shift = flags_new;
        end
        st_next.cnt      = cnt_inc;
        st_next.body_pos = pos_inc;
        if (frame_done) begin
          st_next.cnt = '0;
          if (padding) begin
            st_next.phase = PH_IDLE;
          end else begin
            st_next.skip_rem = cur.size_shift;
            st_next.phase    = (cur.size_shift != 32'd0) ? PH_SKIP : PH_FRAME;
          end
        end
        if (body_end) begin
          st_next.phase = PH_IDLE;
        end
      end
      PH_SKIP: begin
        st_next.skip_rem = skip_dec;
        st_next.body_pos = pos_inc;
        if (skip_dec == 32'd0) begin
          st_next.cnt   = '0;
          st_next.phase = PH_FRAME;
        end
        if (body_end) begin
          st_next.phase = PH_IDLE;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    hdr_rec                      = rec_t'('0);
    hdr_rec.version_major        = cur.hver;
    hdr_rec.unsync_flag          = cur.hflags[2];
    hdr_rec.extended_header_flag = cur.hflags[1];
    hdr_rec.experimental_flag    = cur.hflags[0];
    hdr_rec.tag_size             = hsize;
  end

  always_comb begin
    rec_a     = rec_t'('0);
    rec_b     = hdr_rec;
    rec_b.record_kind = KIND_END;
    rec_count = 2'd0;
    unique case (cur.phase)
      PH_SIG: begin
        if (data_byte != sig_char) begin
          rec_a.record_kind = KIND_ERROR;
          rec_count         = 2'd1;
        end
      end
      PH_VER: begin
        if (cur.cnt == 4'd0 && !ver_ok) begin
          rec_a.record_kind   = KIND_ERROR;
          rec_a.version_major = data_byte;
          rec_count           = 2'd1;
        end
      end
      PH_SIZE: begin
        if (cur.cnt == 4'd3) begin
          rec_a             = hdr_rec;
          rec_a.record_kind = KIND_HEADER;
          rec_count         = walk ? 2'd1 : 2'd2;
        end
      end
      PH_FRAME: begin
        if (frame_done) begin
          if (padding) begin
            rec_a             = hdr_rec;
            rec_a.record_kind = KIND_END;
            rec_count         = 2'd1;
          end else begin
            rec_a             = hdr_rec;
            rec_a.record_kind = KIND_FRAME;
            rec_a.frame_id    = cur.id_shift;
            rec_a.frame_code  = code;
            rec_a.frame_size  = cur.size_shift;
            rec_a.frame_flags = flags_new;
            rec_count         = body_end ? 2'd2 : 2'd1;
          end
        end else if (body_end) begin
          rec_a             = hdr_rec;
          rec_a.record_kind = KIND_END;
          rec_count         = 2'd1;
        end
      end
      PH_SKIP: begin
        if (body_end) begin
          rec_a             = hdr_rec;
          rec_a.record_kind = KIND_END;
          rec_count         = 2'd1;
        end
      end
      default: begin
      end
    endcase
    rec_a.last_of_run = rec_count == 2'd1;
    rec_b.last_of_run = 1'b1;
  end

  assign push.count  = take ? rec_count : 2'd0;
  assign push.first  = rec_a;
  assign push.second = rec_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= pstate_t'('0);
    end else if (take) begin
      st <= st_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/id3p_queue.sv =====
`default_nettype none
module id3p_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire id3p_pkg::push_t push,
  input  wire logic           pop,
  output logic                room,
  output logic                head_valid,
  output id3p_pkg::rec_t      head
);
  import id3p_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  rec_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW-1:0] wr_ptr_1;
  logic [AW-1:0] wr_ptr_2;
  logic [AW-1:0] rd_ptr_next;
  logic [CW-1:0] fill;
  logic [CW-1:0] fill_next;

  assign wr_ptr_1    = (wr_ptr == LAST) ? '0 : wr_ptr + AW'(1);
  assign wr_ptr_2    = (wr_ptr_1 == LAST) ? '0 : wr_ptr_1 + AW'(1);
  assign rd_ptr_next = (rd_ptr == LAST) ? '0 : rd_ptr + AW'(1);
  assign fill_next   = fill + CW'(push.count) - CW'(pop);

  assign room       = fill <= CW'(DEPTH - 2);
  assign head_valid = fill != '0;
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr_1] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      fill <= fill_next;
      if (pop) begin
        rd_ptr <= rd_ptr_next;
      end
      if (push.count == 2'd1) begin
        wr_ptr <= wr_ptr_1;
      end else if (push.count == 2'd2) begin
        wr_ptr <= wr_ptr_2;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/id3v2_tag_frame_header_parser_core.sv =====
// ID3v2 tag and frame header parser.
// tag_stream (sink): one tag byte per transaction; start_of_tag marks the first
//   byte of a tag and restarts the parser. Bytes outside a tag are dropped.
// records (source): one result record per transaction: tag header, frame
//   header, bad signature or version, end of frames. last_of_run marks the
//   final record caused by one byte; a byte causes zero, one or two records.
// A byte's records are registered in the result queue and are valid on records
//   once they reach its head. Throughput: one byte per cycle while the queue
//   has room; the parser state updates in the cycle the byte is taken and its
//   records land in a QUEUE_DEPTH-entry result queue. Records drain one per
//   cycle while records.ready is high, so a byte's two records leave separately.
// tag_stream.ready is high while the queue has at least two free entries; a
//   stall on records fills the queue and then holds off new bytes.
// Reset: the parser goes idle and the queue empties; nothing is emitted
//   until a byte with start_of_tag arrives.
`default_nettype none
module id3v2_tag_frame_header_parser_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input wire logic   clk,
  input wire logic   rst,
  id3p_byte_if.sink  tag_stream,
  id3p_rec_if.source records
);
  import id3p_pkg::*;

  push_t push;
  rec_t  head;
  logic  room;
  logic  head_valid;
  logic  take;
  logic  pop;

  assign take = tag_stream.valid && room;
  assign pop  = head_valid && records.ready;

  assign tag_stream.ready = room;

  id3p_parse u_parse (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .data_byte    (tag_stream.data_byte),
    .start_of_tag (tag_stream.start_of_tag),
    .push         (push)
  );

  id3p_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .pop        (pop),
    .room       (room),
    .head_valid (head_valid),
    .head       (head)
  );

  assign records.valid                = head_valid;
  assign records.record_kind          = head.record_kind;
  assign records.version_major        = head.version_major;
  assign records.unsync_flag          = head.unsync_flag;
  assign records.extended_header_flag = head.extended_header_flag;
  assign records.experimental_flag    = head.experimental_flag;
  assign records.tag_size             = head.tag_size;
  assign records.frame_id             = head.frame_id;
  assign records.frame_code           = head.frame_code;
  assign records.frame_size           = head.frame_size;
  assign records.frame_flags          = head.frame_flags;
  assign records.last_of_run          = head.last_of_run;

endmodule
`default_nettype wire

// ===== rtl/id3p_checker.sv =====
`default_nettype none
module id3p_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        valid,
  input wire logic        ready,
  input wire logic [1:0]  record_kind,
  input wire logic [7:0]  version_major,
  input wire logic [27:0] tag_size,
  input wire logic [31:0] frame_id,
  input wire logic [6:0]  frame_code,
  input wire logic [31:0] frame_size,
  input wire logic [15:0] frame_flags,
  input wire logic        last_of_run
);
  import id3p_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid && $stable(record_kind) && $stable(frame_id)
      && $stable(last_of_run))
    else $error("record changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !valid)
    else $error("record valid right after reset");

  a_frame_fields: assert property (@(posedge clk) disable iff (rst)
    valid && record_kind != KIND_FRAME |-> frame_id == 32'd0 && frame_code == 7'd0
      && frame_size == 32'd0 && frame_flags == 16'd0)
    else $error("frame fields set outside a frame record");

  a_error_alone: assert property (@(posedge clk) disable iff (rst)
    valid && record_kind == KIND_ERROR |-> last_of_run && tag_size == 28'd0)
    else $error("error record not alone or carries a size");

  a_short_tag: assert property (@(posedge clk) disable iff (rst)
    valid && record_kind == KIND_HEADER && version_major != VER_3
      && version_major != VER_4 |-> !last_of_run)
    else $error("header without frame walk not followed by end record");

endmodule

bind id3v2_tag_frame_header_parser_core id3p_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .valid         (records.valid),
  .ready         (records.ready),
  .record_kind   (records.record_kind),
  .version_major (records.version_major),
  .tag_size      (records.tag_size),
  .frame_id      (records.frame_id),
  .frame_code    (records.frame_code),
  .frame_size    (records.frame_size),
  .frame_flags   (records.frame_flags),
  .last_of_run   (records.last_of_run)
);
`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
module testbench;
  import id3p_pkg::*;

  localparam int RANDOM_ITEMS = 1100;
  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 20;

  localparam logic [1:0] USE_MODEL  = 2'd0;
  localparam logic [1:0] NO_RECORD  = 2'd1;
  localparam logic [1:0] ONE_RECORD = 2'd2;

  localparam logic [74*32-1:0] KNOWN_IDS = {
    "AENCAPICCOMMCOMRENCREQUAETCOGEOBGRIDIPLS",
    "LINKMCDIMLLTOWNEPRIVPCNTPOPMPOSSRBUFRVAD",
    "RVRBSYLTSYTCTALBTBPMTCOMTCONTCOPTDATTDLY",
    "TENCTEXTTFLTTIMETIT1TIT2TIT3TKEYTLANTLEN",
    "TMEDTOALTOFNTOLYTOPETORYTOWNTPE1TPE2TPE3",
    "TPE4TPOSTPUBTRCKTRDATRSNTRSOTSIZTSRCTSSE",
    "TYERTXXXUFIDUSERUSLTWCOMWCOPWOAFWOARWOAS",
    "WORSWPAYWPUBWXXX"
  };

  typedef struct packed {
    logic [7:0] data;
    logic       sot;
    logic [1:0] lit;
    rec_t       want;
  } step_row_t;

  logic clk = 1'b0;
  logic rst;

  id3p_byte_if tag_stream_bus ();
  id3p_rec_if records_bus ();

  id3v2_tag_frame_header_parser_core DUT (
    .clk(clk),
    .rst(rst),
    .tag_stream(tag_stream_bus),
    .records(records_bus)
  );

  phase_t      walk_phase;
  logic [3:0]  byte_index;
  logic [7:0]  tag_version;
  logic [2:0]  tag_flags;
  logic [27:0] body_bytes;
  logic [27:0] body_offset;
  logic [31:0] id_acc;
  logic [31:0] size_acc;
  logic [15:0] flags_acc;
  logic [31:0] payload_left;

  rec_t      step_recs[$];
  rec_t      predicted_records[$];
  step_row_t directed_rows[$];
  logic [8:0] tag_burst[$];

  int send_idle_pct;
  int stall_pct;
  int mismatch_count;
  int bytes_sent;
  int records_checked;
  int frame_records;
  int tags_walked;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] known_id(input int k);
    return KNOWN_IDS[(73 - k) * 32 +: 32];
  endfunction

  function automatic logic [6:0] id_code(input logic [31:0] id);
    logic [6:0] code;
    code = '0;
    for (int k = 0; k < 74; k++) begin
      if (code == 0 && known_id(k) == id) code = 7'(k + 1);
    end
    return code;
  endfunction

  function automatic logic [7:0] sig_char(input int k);
    case (k)
      0: return SIG_0;
      1: return SIG_1;
      default: return SIG_2;
    endcase
  endfunction

  function automatic rec_t make_rec(input logic [1:0] kind, input logic hdr,
                                    input logic [31:0] fid, input logic [6:0] code,
                                    input logic [31:0] fsize, input logic [15:0] fflags);
    rec_t r;
    r = '0;
    r.record_kind = kind;
    if (hdr) begin
      r.version_major = tag_version;
      r.unsync_flag = tag_flags[2];
      r.extended_header_flag = tag_flags[1];
      r.experimental_flag = tag_flags[0];
      r.tag_size = body_bytes;
    end
    r.frame_id = fid;
    r.frame_code = code;
    r.frame_size = fsize;
    r.frame_flags = fflags;
    return r;
  endfunction

  function automatic rec_t error_record(input logic [7:0] v);
    rec_t r;
    r = '0;
    r.record_kind = KIND_ERROR;
    r.version_major = v;
    r.last_of_run = 1'b1;
    return r;
  endfunction

  task automatic clear_parse_state();
    walk_phase = PH_IDLE;
    byte_index = '0;
    tag_version = '0;
    tag_flags = '0;
    body_bytes = '0;
    body_offset = '0;
    id_acc = '0;
    size_acc = '0;
    flags_acc = '0;
    payload_left = '0;
  endtask

  task automatic parse_tag_byte(input logic [7:0] b, input logic sot);
    logic [6:0] code;
    logic padded;
    rec_t r;
    step_recs.delete();
    padded = 1'b0;
    if (sot) begin
      clear_parse_state();
      walk_phase = PH_SIG;
    end
    case (walk_phase)
      PH_SIG: begin
        if (b != sig_char(int'(byte_index))) begin
          step_recs.push_back(make_rec(KIND_ERROR, 1'b0, '0, '0, '0, '0));
          walk_phase = PH_IDLE;
        end else if (byte_index == 4'd2) begin
          byte_index = '0;
          walk_phase = PH_VER;
        end else begin
          byte_index++;
        end
      end
      PH_VER: begin
        if (byte_index == 4'd0) begin
          if (!(b inside {VER_0, VER_2, VER_3, VER_4})) begin
            r = make_rec(KIND_ERROR, 1'b0, '0, '0, '0, '0);
            r.version_major = b;
            step_recs.push_back(r);
            walk_phase = PH_IDLE;
          end else begin
            tag_version = b;
            byte_index = 4'd1;
          end
        end else begin
          byte_index = '0;
          walk_phase = PH_FLAGS;
        end
      end
      PH_FLAGS: begin
        tag_flags = b[7:5];
        byte_index = '0;
        size_acc = '0;
        walk_phase = PH_SIZE;
      end
      PH_SIZE: begin
        size_acc = ((size_acc << 7) | {25'b0, b[6:0]}) & 32'h0FFF_FFFF;
        byte_index++;
        if (byte_index == 4'd4) begin
          body_bytes = size_acc[27:0];
          body_offset = '0;
          byte_index = '0;
          step_recs.push_back(make_rec(KIND_HEADER, 1'b1, '0, '0, '0, '0));
          if ((tag_version == VER_3 || tag_version == VER_4) && body_bytes != 0) begin
            walk_phase = PH_FRAME;
          end else begin
            step_recs.push_back(make_rec(KIND_END, 1'b1, '0, '0, '0, '0));
            walk_phase = PH_IDLE;
          end
        end
      end
      PH_FRAME: begin
        if (byte_index < 4) id_acc = {id_acc[23:0], b};
        else if (byte_index < 8) size_acc = {size_acc[23:0], b};
        else flags_acc = {flags_acc[7:0], b};
        byte_index++;
        body_offset++;
        if (byte_index == 4'd10) begin
          code = id_code(id_acc);
          byte_index = '0;
          if (code == 0 && size_acc == 0) begin
            step_recs.push_back(make_rec(KIND_END, 1'b1, '0, '0, '0, '0));
            walk_phase = PH_IDLE;
            padded = 1'b1;
          end else begin
            step_recs.push_back(make_rec(KIND_FRAME, 1'b1, id_acc, code, size_acc, flags_acc));
            payload_left = size_acc;
            walk_phase = (payload_left != 0) ? PH_SKIP : PH_FRAME;
          end
        end
        if (!padded && body_offset >= body_bytes) begin
          step_recs.push_back(make_rec(KIND_END, 1'b1, '0, '0, '0, '0));
          walk_phase = PH_IDLE;
        end
      end
      PH_SKIP: begin
        payload_left--;
        body_offset++;
        if (payload_left == 0) begin
          byte_index = '0;
          walk_phase = PH_FRAME;
        end
        if (body_offset >= body_bytes) begin
          step_recs.push_back(make_rec(KIND_END, 1'b1, '0, '0, '0, '0));
          walk_phase = PH_IDLE;
        end
      end
      default: ;
    endcase
    if (step_recs.size() > 0) step_recs[step_recs.size() - 1].last_of_run = 1'b1;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    $display("%0t: %s got %0h expected %0h", $time, what, got, want);
  endtask

  task automatic check_record();
    rec_t got;
    rec_t want;
    got.record_kind = records_bus.record_kind;
    got.version_major = records_bus.version_major;
    got.unsync_flag = records_bus.unsync_flag;
    got.extended_header_flag = records_bus.extended_header_flag;
    got.experimental_flag = records_bus.experimental_flag;
    got.tag_size = records_bus.tag_size;
    got.frame_id = records_bus.frame_id;
    got.frame_code = records_bus.frame_code;
    got.frame_size = records_bus.frame_size;
    got.frame_flags = records_bus.frame_flags;
    got.last_of_run = records_bus.last_of_run;
    records_checked++;
    if (got.record_kind == KIND_FRAME) frame_records++;
    if (predicted_records.size() == 0) begin
      report_mismatch("unexpected record, kind", 32'(got.record_kind), '0);
    end else begin
      want = predicted_records.pop_front();
      if (got.record_kind !== want.record_kind)
        report_mismatch("record_kind", 32'(got.record_kind), 32'(want.record_kind));
      if (got.version_major !== want.version_major)
        report_mismatch("version_major", 32'(got.version_major), 32'(want.version_major));
      if (got.unsync_flag !== want.unsync_flag)
        report_mismatch("unsync_flag", 32'(got.unsync_flag), 32'(want.unsync_flag));
      if (got.extended_header_flag !== want.extended_header_flag)
        report_mismatch("extended_header_flag", 32'(got.extended_header_flag),
                        32'(want.extended_header_flag));
      if (got.experimental_flag !== want.experimental_flag)
        report_mismatch("experimental_flag", 32'(got.experimental_flag),
                        32'(want.experimental_flag));
      if (got.tag_size !== want.tag_size)
        report_mismatch("tag_size", 32'(got.tag_size), 32'(want.tag_size));
      if (got.frame_id !== want.frame_id)
        report_mismatch("frame_id", got.frame_id, want.frame_id);
      if (got.frame_code !== want.frame_code)
        report_mismatch("frame_code", 32'(got.frame_code), 32'(want.frame_code));
      if (got.frame_size !== want.frame_size)
        report_mismatch("frame_size", got.frame_size, want.frame_size);
      if (got.frame_flags !== want.frame_flags)
        report_mismatch("frame_flags", 32'(got.frame_flags), 32'(want.frame_flags));
      if (got.last_of_run !== want.last_of_run)
        report_mismatch("last_of_run", 32'(got.last_of_run), 32'(want.last_of_run));
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic sot, input logic [1:0] lit,
                           input rec_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      tag_stream_bus.valid <= 1'b0;
      @(negedge clk);
    end
    tag_stream_bus.valid <= 1'b1;
    tag_stream_bus.data_byte <= b;
    tag_stream_bus.start_of_tag <= sot;
    @(posedge clk);
    while (!tag_stream_bus.ready) @(posedge clk);
    parse_tag_byte(b, sot);
    if (lit == USE_MODEL) begin
      foreach (step_recs[k]) predicted_records.push_back(step_recs[k]);
    end else if (lit == ONE_RECORD) begin
      predicted_records.push_back(want);
    end
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic add_row(input logic [7:0] data, input logic sot, input logic [1:0] lit,
                         input rec_t want);
    step_row_t row;
    row.data = data;
    row.sot = sot;
    row.lit = lit;
    row.want = want;
    directed_rows.push_back(row);
  endtask

  task automatic build_tag();
    int pick;
    int cut;
    int plen;
    int shrink;
    logic [7:0] b;
    logic [7:0] ver;
    logic [31:0] fid;
    logic [31:0] fsize;
    logic [27:0] bsize;
    logic stop;
    logic [7:0] body[$];
    tag_burst.delete();
    body.delete();
    stop = 1'b0;
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      repeat ($urandom_range(1, 4)) tag_burst.push_back({1'b0, 8'($urandom)});
      return;
    end
    cut = (pick < 14) ? int'($urandom_range(0, 2)) : 3;
    for (int k = 0; k < 3 && k <= cut; k++) begin
      b = sig_char(k);
      if (k == cut) begin
        b = 8'($urandom);
        if (b == sig_char(k)) b = b ^ 8'h20;
      end
      tag_burst.push_back({k == 0, b});
    end
    if (cut < 3) return;
    if (pick < 22) begin
      do ver = 8'($urandom); while (ver inside {VER_0, VER_2, VER_3, VER_4});
      tag_burst.push_back({1'b0, ver});
      return;
    end
    if (pick < 34) begin
      ver = $urandom_range(0, 1) ? VER_0 : VER_2;
    end else begin
      ver = $urandom_range(0, 1) ? VER_3 : VER_4;
      tags_walked++;
    end
    tag_burst.push_back({1'b0, ver});
    tag_burst.push_back({1'b0, 8'($urandom)});
    tag_burst.push_back({1'b0, 8'($urandom)});
    if (ver == VER_3 || ver == VER_4) begin
      repeat ($urandom_range(0, 4)) if (!stop) begin
        pick = $urandom_range(0, 99);
        fid = (pick < 70) ? known_id(int'($urandom_range(0, 73))) : $urandom;
        fsize = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 5);
        if (pick >= 92) begin
          fid = (pick >= 96) ? 32'h0 : $urandom;
          fsize = '0;
          stop = 1'b1;
        end
        for (int k = 3; k >= 0; k--) body.push_back(fid[8*k +: 8]);
        for (int k = 3; k >= 0; k--) body.push_back(fsize[8*k +: 8]);
        repeat (2) body.push_back(8'($urandom));
        if (fsize > 6) plen = 6;
        else plen = int'(fsize);
        repeat (plen) body.push_back(8'($urandom));
        if (fsize > 6) stop = 1'b1;
      end
      if (stop && $urandom_range(0, 1)) repeat ($urandom_range(1, 4)) body.push_back(8'h00);
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        bsize = 28'(body.size());
      end else if (pick < 78) begin
        shrink = $urandom_range(1, 9);
        bsize = (body.size() > shrink) ? 28'(body.size() - shrink) : 28'd1;
      end else if (pick < 88) begin
        bsize = '0;
        body.delete();
      end else begin
        bsize = 28'($urandom);
      end
    end else begin
      bsize = 28'($urandom);
    end
    for (int k = 3; k >= 0; k--) tag_burst.push_back({1'b0, 1'($urandom), bsize[7*k +: 7]});
    foreach (body[k]) tag_burst.push_back({1'b0, body[k]});
    if ($urandom_range(0, 19) == 0) begin
      cut = $urandom_range(1, tag_burst.size());
      while (tag_burst.size() > cut) void'(tag_burst.pop_back());
    end
  endtask

  always @(negedge clk) begin
    records_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && records_bus.valid && records_bus.ready) check_record();
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((tag_stream_bus.valid && tag_stream_bus.ready) ||
          (records_bus.valid && records_bus.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("no transaction for %0d cycles", IDLE_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    int scored;
    int mix;
    rst = 1'b1;
    tag_stream_bus.valid = 1'b0;
    tag_stream_bus.data_byte = '0;
    tag_stream_bus.start_of_tag = 1'b0;
    records_bus.ready = 1'b0;
    send_idle_pct = 0;
    stall_pct = 0;
    mismatch_count = 0;
    bytes_sent = 0;
    records_checked = 0;
    frame_records = 0;
    tags_walked = 0;
    scored = 0;
    clear_parse_state();

    add_row(8'hFF, 1'b0, NO_RECORD,  '0);
    add_row(SIG_0, 1'b1, USE_MODEL,  '0);
    add_row(8'h00, 1'b0, ONE_RECORD, error_record(8'h00));
    add_row(SIG_0, 1'b1, USE_MODEL,  '0);
    add_row(SIG_1, 1'b0, USE_MODEL,  '0);
    add_row(SIG_2, 1'b0, USE_MODEL,  '0);
    add_row(8'hFF, 1'b0, ONE_RECORD, error_record(8'hFF));
    add_row(8'h41, 1'b1, ONE_RECORD, error_record(8'h00));
    add_row(8'h12, 1'b0, NO_RECORD,  '0);
    add_row(SIG_0, 1'b1, USE_MODEL,  '0);
    add_row(SIG_1, 1'b0, USE_MODEL,  '0);
    add_row(SIG_2, 1'b0, USE_MODEL,  '0);
    add_row(VER_2, 1'b0, USE_MODEL,  '0);
    add_row(8'hFF, 1'b0, USE_MODEL,  '0);
    add_row(8'hE0, 1'b0, USE_MODEL,  '0);
    add_row(8'hFF, 1'b0, USE_MODEL,  '0);
    add_row(8'h80, 1'b0, USE_MODEL,  '0);
    add_row(8'h80, 1'b0, USE_MODEL,  '0);
    add_row(8'h81, 1'b0, USE_MODEL,  '0);
    add_row(8'h00, 1'b0, NO_RECORD,  '0);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[k]) begin
      send_byte(directed_rows[k].data, directed_rows[k].sot, directed_rows[k].lit,
                directed_rows[k].want);
    end

    while (scored < RANDOM_ITEMS) begin
      mix = scored * 5 / RANDOM_ITEMS;
      case (mix)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 82; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 82; end
        3: begin send_idle_pct = 24; stall_pct = 24; end
        default: begin send_idle_pct = 0; stall_pct = 0; end
      endcase
      build_tag();
      foreach (tag_burst[k]) send_byte(tag_burst[k][7:0], tag_burst[k][8], USE_MODEL, '0);
      if (tag_burst[0][8]) scored += tag_burst.size();
    end
    tag_stream_bus.valid <= 1'b0;

    while (predicted_records.size() != 0) @(posedge clk);
    stall_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d tag bytes, %0d tags walked frame by frame, under four idle mixes",
             bytes_sent, tags_walked);
    $display("checked %0d records, %0d frame headers, %0d mismatches",
             records_checked, frame_records, mismatch_count);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/id3p_pkg.sv
rtl/id3p_if.sv
rtl/id3p_parse.sv
rtl/id3p_queue.sv
rtl/id3v2_tag_frame_header_parser_core.sv
rtl/id3p_checker.sv
sim/testbench.sv
